[sv/bbe_pkg.sv]
// Shared constants and types for the bounding box extent unit.
`default_nettype none

package bbe_pkg;

    localparam int COORD_BITS_DEF = 32;   // default coordinate width
    localparam int FIELD_W        = 32;   // width of each coordinate field on the ports
    localparam int DIAG_W         = 33;   // width of the diagonal result
    localparam int IN_TDATA_W     = 3 * FIELD_W;
    localparam int OUT_FIELDS_W   = 11 * FIELD_W + DIAG_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_FIELDS_W;

    // status of the iterative square root unit
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage : bbe_pkg

`default_nettype wire

[sv/bounding_box_extent_unit.sv]
// Top level of the bounding box extent unit: sequencer, shared multiplier and result register.
//
// Input stream: s_tdata carries vertex_x, vertex_y, vertex_z (low 32 bits first), each a
// signed Q16.16 value of which the low COORD_BITS bits are used, sign-extended. s_tlast
// marks the final vertex of a set. A transaction completes when s_tvalid and s_tready are high.
// Result stream: one transaction per set on m_tdata, emitted after its last vertex: box
// corners, axis extents, largest extents and the diagonal, packed as listed at the port.
// A vertex that is not last is folded into the running minima and maxima and s_tready
// stays high. A last vertex forms the extents, squares and sums them through the single
// multiplier, starts the square root, runs its COORD_BITS + 1 root-bit steps, then
// finishes and loads the result register; s_tready is low over that time. The root
// unit's recurrence produces one root bit per cycle.
// A finished result waits in the output register while the next set streams in; if it
// is still untaken when the next set finishes, the sequencer holds there until m_tready.
// Reset (aresetn low, synchronous) seeds the running minima at the most positive value,
// the maxima at the most negative, and empties the result register.
`default_nettype none

module bounding_box_extent_unit
    import bbe_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // vertex_x [31:0], vertex_y [63:32], vertex_z [95:64]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, extent_x, extent_y,
    // extent_z, largest_extent_all, largest_extent_xz (32 bits each from bit 0),
    // diagonal_length [384:352], zero fill [391:385]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int RAD_W  = 2 * COORD_BITS + 2;
    localparam int PROD_W = 2 * COORD_BITS;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXT   = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_START = 7'b0010000,
        ST_ROOT  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic                         s_accept;
    logic signed [COORD_BITS-1:0] vtx     [3];
    logic signed [COORD_BITS-1:0] cap_min [3];
    logic signed [COORD_BITS-1:0] cap_max [3];

    logic [1:0]            cnt_reg;
    logic [COORD_BITS-1:0] ext_reg [3];
    logic [COORD_BITS-1:0] xz_reg;
    logic [COORD_BITS-1:0] all_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [RAD_W-1:0]      acc_reg;
    logic [COORD_BITS-1:0] mul_op;

    sqrt_stat_t            sq_stat;
    logic [COORD_BITS:0]   sq_root;
    logic                  sq_start;

    logic                  out_load;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vtx[i] = s_tdata[i*FIELD_W +: COORD_BITS];
        end
    end

    bbe_minmax #(
        .COORD_BITS (COORD_BITS)
    ) u_minmax (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .last    (s_tlast),
        .vtx     (vtx),
        .cap_min (cap_min),
        .cap_max (cap_max)
    );

    bbe_isqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (acc_reg),
        .stat     (sq_stat),
        .root     (sq_root)
    );

    assign sq_start = (state_reg == ST_START);
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign mul_op   = ext_reg[cnt_reg];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept && s_tlast) state_next = ST_EXT;
            ST_EXT:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = (cnt_reg == 2'd2) ? ST_START : ST_MUL;
            ST_START: state_next = ST_ROOT;
            ST_ROOT:  if (sq_stat.done) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EXT) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_ACC) begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath: extents, shared squarer, sum of squares
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_EXT: begin
                for (int i = 0; i < 3; i++) begin
                    ext_reg[i] <= COORD_BITS'(cap_max[i] - cap_min[i]);
                end
                acc_reg <= '0;
            end
            ST_MUL: begin
                prod_reg <= PROD_W'(mul_op) * PROD_W'(mul_op);
                // largest extents ride along the squaring steps
                if (cnt_reg == 2'd0) begin
                    xz_reg <= (ext_reg[0] > ext_reg[2]) ? ext_reg[0] : ext_reg[2];
                end
                if (cnt_reg == 2'd1) begin
                    all_reg <= (xz_reg > ext_reg[1]) ? xz_reg : ext_reg[1];
                end
            end
            ST_ACC: begin
                acc_reg <= acc_reg + RAD_W'(prod_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {
                {OUT_PAD_W{1'b0}},
                DIAG_W'(sq_root),
                FIELD_W'(xz_reg),
                FIELD_W'(all_reg),
                FIELD_W'(ext_reg[2]),
                FIELD_W'(ext_reg[1]),
                FIELD_W'(ext_reg[0]),
                FIELD_W'(cap_max[2]),
                FIELD_W'(cap_max[1]),
                FIELD_W'(cap_max[0]),
                FIELD_W'(cap_min[2]),
                FIELD_W'(cap_min[1]),
                FIELD_W'(cap_min[0])
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : bounding_box_extent_unit

`default_nettype wire

[sv/bbe_minmax.sv]
// Running per-axis minimum and maximum, captured and reset at the end of each set.
`default_nettype none

module bbe_minmax
    import bbe_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept,
    input  wire logic                         last,
    input  wire logic signed [COORD_BITS-1:0] vtx     [3],
    output logic signed      [COORD_BITS-1:0] cap_min [3],
    output logic signed      [COORD_BITS-1:0] cap_max [3]
);

    localparam logic signed [COORD_BITS-1:0] C_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] min_reg [3];
    logic signed [COORD_BITS-1:0] max_reg [3];
    logic signed [COORD_BITS-1:0] min_next [3];
    logic signed [COORD_BITS-1:0] max_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            min_next[i] = (vtx[i] < min_reg[i]) ? vtx[i] : min_reg[i];
            max_next[i] = (vtx[i] > max_reg[i]) ? vtx[i] : max_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                min_reg[i] <= C_HI;
                max_reg[i] <= C_LO;
            end
        end else if (accept) begin
            for (int i = 0; i < 3; i++) begin
                // the last vertex of a set returns the running state to its seeds
                min_reg[i] <= last ? C_HI : min_next[i];
                max_reg[i] <= last ? C_LO : max_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last) begin
            for (int i = 0; i < 3; i++) begin
                cap_min[i] <= min_next[i];
                cap_max[i] <= max_next[i];
            end
        end
    end

endmodule : bbe_minmax

`default_nettype wire

[sv/bbe_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module bbe_isqrt
    import bbe_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [2*COORD_BITS+1:0]   radicand,
    output sqrt_stat_t                     stat,
    output logic      [COORD_BITS:0]       root
);

    localparam int RAD_W  = 2 * COORD_BITS + 2;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // bring down the next pair of radicand bits and try root*4+1
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ROOT_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule : bbe_isqrt

`default_nettype wire
